// ===== hw/rtl/stil_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stil_pkg: shared types and constants
// sizes, action codes and controller command/status bundles
// ----------------------------------------------------------------------------
package stil_pkg;

  localparam int MaxSamples = 1024;
  localparam int FracBits   = 16;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = AddrW + 1;
  localparam int DivW       = 32 + FracBits + 1;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic clear;      // empty table
    logic append;     // write sample / drop
    logic rd_first;   // read entry 0
    logic rd_last;    // read last entry
    logic rd_mid;     // read probe entry
    logic cap_first;  // latch first time
    logic cap_last;   // latch last time
    logic probe;      // evaluate probe data
    logic rd_lo;      // read bracket low
    logic rd_hi;      // read bracket high
    logic cap_lo;     // latch low sample
    logic cap_hi;     // latch high sample
    logic div_start;  // start fraction divider
    logic div_step;   // one divider step
    logic mul_step;   // one component multiply
    logic res_miss;   // load miss result
    logic res_exact;  // load exact result
    logic res_lo;     // load low sample as result
    logic res_interp; // load interpolated result
  } stil_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_append;
    logic is_query;
    logic is_clear;
    logic empty;
    logic out_span;
    logic search_done;
    logic found;
    logic degenerate;
    logic div_done;
    logic mul_done;
  } stil_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stil_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stil_datapath: sample store, search, divider and interpolator
// one synchronous memory port, bit-serial divider, shared multiplier
// ----------------------------------------------------------------------------
module stil_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire stil_pkg::stil_cmd_t  cmd,
  output stil_pkg::stil_sts_t       sts,
  input  wire logic [135:0]         in_word,
  output logic [135:0]              res_word
);
  import stil_pkg::*;

  logic [127:0] mem [MaxSamples];
  logic [127:0] rd_data_r;
  logic [AddrW-1:0] rd_addr;
  logic rd_en;

  logic [1:0]  act_r;
  logic signed [31:0] px_r, py_r, qt_r, sc_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic drop_r, drop_nxt;
  logic signed [31:0] t_first_r, t_last_r;

  // search bounds, signed so hi may go below zero
  logic signed [CntW:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [CntW:0] mid;
  logic found_r, found_nxt;
  logic [127:0] lo_smp_r, hi_smp_r;

  logic [DivW-1:0] num_r, rem_r;
  logic [32:0] den_r;
  logic [FracBits-1:0] u_r;
  logic [$clog2(DivW+1)-1:0] div_cnt_r;
  logic [1:0] mul_idx_r;
  logic mul_done_r;
  logic signed [31:0] res_v_r [4];
  logic hit_r;

  logic signed [31:0] mt;
  assign mt  = rd_data_r[95:64];
  assign mid = lo_r + ((hi_r - lo_r) >>> 1);

  // memory port address select
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    priority if (cmd.rd_first) rd_addr = '0;
    else if (cmd.rd_last)  rd_addr = AddrW'(cnt_r - CntW'(1));
    else if (cmd.rd_mid)   rd_addr = mid[AddrW-1:0];
    else if (cmd.rd_lo)    rd_addr = (hi_r < 0) ? '0 : hi_r[AddrW-1:0];
    else if (cmd.rd_hi)    rd_addr =
                             (lo_r > $signed({1'b0, cnt_r}) - $signed((CntW+1)'(1)))
                             ? AddrW'(cnt_r - CntW'(1)) : lo_r[AddrW-1:0];
    else rd_en = 1'b0;
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (cmd.append && cnt_r < CntW'(MaxSamples) &&
        (cnt_r == '0 || qt_r > t_last_r))
      mem[cnt_r[AddrW-1:0]] <= {sc_r, qt_r, py_r, px_r};
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // table count and drop flag
  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (cmd.clear) begin
      cnt_nxt  = '0;
      drop_nxt = 1'b0;
    end else if (cmd.append) begin
      if (cnt_r < CntW'(MaxSamples) && (cnt_r == '0 || qt_r > t_last_r))
        cnt_nxt = cnt_r + CntW'(1);
      else
        drop_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  // last stored time kept in a register for the order check
  always_ff @(posedge clk) begin
    if (cmd.append && cnt_r < CntW'(MaxSamples) && (cnt_r == '0 || qt_r > t_last_r))
      t_last_r <= qt_r;
    else if (cmd.cap_last)
      t_last_r <= mt;
    if (cmd.cap_first) t_first_r <= mt;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_word[1:0];
      px_r  <= in_word[33:2];
      py_r  <= in_word[65:34];
      qt_r  <= in_word[97:66];
      sc_r  <= in_word[129:98];
    end
  end

  // binary search step
  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    found_nxt = found_r;
    if (cmd.load) begin
      lo_nxt    = '0;
      hi_nxt    = $signed({1'b0, cnt_r}) - $signed((CntW+1)'(1));
      found_nxt = 1'b0;
    end else if (cmd.probe) begin
      if (mt < qt_r)      lo_nxt = mid + $signed((CntW+1)'(1));
      else if (mt > qt_r) hi_nxt = mid - $signed((CntW+1)'(1));
      else                found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0; hi_r <= '0; found_r <= 1'b0;
    end else begin
      lo_r <= lo_nxt; hi_r <= hi_nxt; found_r <= found_nxt;
    end
  end

  // bracket capture and divider, one quotient bit per cycle
  logic [DivW-1:0] rem_sh;
  assign rem_sh = {rem_r[DivW-2:0], num_r[DivW-1]};
  always_ff @(posedge clk) begin
    if (cmd.cap_lo) lo_smp_r <= rd_data_r;
    if (cmd.cap_hi) hi_smp_r <= rd_data_r;
    if (cmd.probe && mt == qt_r) lo_smp_r <= rd_data_r;
    if (cmd.div_start) begin
      num_r     <= DivW'({33'(signed'(qt_r) - signed'(lo_smp_r[95:64]))}) << FracBits;
      den_r     <= 33'(signed'(hi_smp_r[95:64]) - signed'(lo_smp_r[95:64]));
      rem_r     <= '0;
      u_r       <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      num_r     <= {num_r[DivW-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + 1'b1;
      if (rem_sh >= DivW'(den_r)) begin
        rem_r <= rem_sh - DivW'(den_r);
        u_r   <= {u_r[FracBits-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        u_r   <= {u_r[FracBits-2:0], 1'b0};
      end
    end
  end

  // one component per cycle through a shared multiplier
  logic signed [31:0] a0, a1;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  always_comb begin
    unique case (mul_idx_r)
      2'd0: begin a0 = lo_smp_r[31:0];   a1 = hi_smp_r[31:0];   end
      2'd1: begin a0 = lo_smp_r[63:32];  a1 = hi_smp_r[63:32];  end
      2'd2: begin a0 = lo_smp_r[95:64];  a1 = hi_smp_r[95:64];  end
      default: begin a0 = lo_smp_r[127:96]; a1 = hi_smp_r[127:96]; end
    endcase
    diff = 33'(a1) - 33'(a0);
    prod = 50'(diff) * $signed({1'b0, u_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_idx_r  <= '0;
      mul_done_r <= 1'b0;
    end else if (cmd.div_start) begin
      mul_idx_r  <= '0;
      mul_done_r <= 1'b0;
    end else if (cmd.mul_step) begin
      mul_idx_r  <= mul_idx_r + 1'b1;
      mul_done_r <= (mul_idx_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step)
      res_v_r[mul_idx_r] <= 32'(a0 + 32'(prod >>> FracBits));
  end

  // result word
  logic [127:0] res_vals_r;
  always_ff @(posedge clk) begin
    if (cmd.res_miss) begin
      hit_r <= 1'b0; res_vals_r <= '0;
    end else if (cmd.res_exact || cmd.res_lo) begin
      hit_r <= 1'b1; res_vals_r <= lo_smp_r;
    end else if (cmd.res_interp) begin
      hit_r <= 1'b1; res_vals_r <= {res_v_r[3], res_v_r[2], res_v_r[1], res_v_r[0]};
    end
  end
  assign res_word = {6'd0, drop_r, res_vals_r, hit_r};

  assign sts.is_append   = (act_r == ACT_APPEND);
  assign sts.is_query    = (act_r == ACT_QUERY);
  assign sts.is_clear    = (act_r == ACT_CLEAR);
  assign sts.empty       = (cnt_r == '0);
  assign sts.out_span    = (qt_r < t_first_r) || (qt_r > t_last_r);
  assign sts.search_done = (lo_r > hi_r) || found_r;
  assign sts.found       = found_r;
  assign sts.degenerate  = (signed'(hi_smp_r[95:64]) <= signed'(lo_smp_r[95:64])) ||
                           (qt_r < signed'(lo_smp_r[95:64]));
  assign sts.div_done    = (div_cnt_r == ($clog2(DivW+1))'(DivW));
  assign sts.mul_done    = mul_done_r;

  // the table never holds more than its capacity
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(MaxSamples))
    else $error("sample count over capacity");
  // a clear empties the table and drops the flag
  assert property (@(posedge clk) disable iff (!rst_n) cmd.clear |=> cnt_r == '0 && !drop_r)
    else $error("clear not applied");
  // probe address stays inside the filled part of the table
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_mid |-> (mid >= 0) && (mid < $signed({1'b0, cnt_r})))
    else $error("probe outside table");
endmodule
`default_nettype wire

// ===== hw/rtl/stil_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stil_ctrl: sequencing state machine
// steps the datapath through clear, append, span check, search, divide, multiply
// ----------------------------------------------------------------------------
module stil_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  output logic                     in_ready,
  output logic                     res_valid,
  input  wire logic                res_taken,
  output stil_pkg::stil_cmd_t      cmd,
  input  wire stil_pkg::stil_sts_t sts
);
  import stil_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DECODE  = 13'b0000000000010,
    S_RD_LAST = 13'b0000000000100,
    S_CAP_L   = 13'b0000000001000,
    S_SPAN    = 13'b0000000010000,
    S_PROBE_R = 13'b0000000100000,
    S_PROBE_W = 13'b0000001000000,
    S_PROBE   = 13'b0000010000000,
    S_RD_HI   = 13'b0000100000000,
    S_CAP_HI  = 13'b0001000000000,
    S_DIV     = 13'b0010000000000,
    S_MUL     = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    res_valid = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load  = 1'b1;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        priority if (sts.is_clear) begin
          cmd.clear = 1'b1; state_nxt = S_IDLE;
        end else if (sts.is_append) begin
          cmd.append = 1'b1; state_nxt = S_IDLE;
        end else if (sts.is_query) begin
          if (sts.empty) begin
            cmd.res_miss = 1'b1; state_nxt = S_OUT;
          end else begin
            cmd.rd_first = 1'b1; state_nxt = S_RD_LAST;
          end
        end else state_nxt = S_IDLE;
      end
      // first entry is on the read data while the last one is fetched
      S_RD_LAST: begin
        cmd.rd_last   = 1'b1;
        cmd.cap_first = 1'b1;
        state_nxt     = S_CAP_L;
      end
      S_CAP_L:   begin cmd.cap_last = 1'b1; state_nxt = S_SPAN; end
      S_SPAN: begin
        if (sts.out_span) begin
          cmd.res_miss = 1'b1; state_nxt = S_OUT;
        end else state_nxt = S_PROBE_R;
      end
      S_PROBE_R: begin
        if (sts.search_done) begin
          if (sts.found) begin
            cmd.res_exact = 1'b1; state_nxt = S_OUT;
          end else begin
            cmd.rd_lo = 1'b1; state_nxt = S_RD_HI;
          end
        end else begin
          cmd.rd_mid = 1'b1; state_nxt = S_PROBE_W;
        end
      end
      S_PROBE_W: state_nxt = S_PROBE;
      S_PROBE:   begin cmd.probe = 1'b1; state_nxt = S_PROBE_R; end
      // low bracket is on the read data while the high one is fetched
      S_RD_HI: begin
        cmd.rd_hi  = 1'b1;
        cmd.cap_lo = 1'b1;
        state_nxt  = S_CAP_HI;
      end
      S_CAP_HI:  begin
        cmd.cap_hi    = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.degenerate) begin
          cmd.res_lo = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1; state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (!sts.div_done) cmd.div_step = 1'b1;
        else if (!sts.mul_done) cmd.mul_step = 1'b1;
        else begin
          cmd.res_interp = 1'b1; state_nxt = S_OUT;
        end
      end
      S_OUT: if (res_taken) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // a word is offered only after a query walk
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid) |-> $past(state_r) != S_IDLE)
    else $error("result without query");
  // no input is taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> !in_ready)
    else $error("input accepted during output");
  // exactly one state bit
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state encoding broken");
endmodule
`default_nettype wire

// ===== hw/rtl/sorted_table_interpolating_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_interpolating_lookup: sorted sample table with lookup
// appends samples in time order; queries search and interpolate in Q16.16
// ----------------------------------------------------------------------------
// channel | dir | fields
// in_     | in  | tdata: action, pos_x, pos_y, sample_time, scalar_value
// out_    | out | tdata: hit, out_x, out_y, out_time, out_scalar, dropped_flag
//
// clear and append return to idle after decode; a query passes the accept and
// result states, four memory reads, a read, wait and compare state per binary
// search probe (up to 11 probes), one divider step per quotient bit and one
// multiply per component, all through one read port of the sample memory.
// reset empties the table; the memory itself is not cleared.
// the result is held in a register until taken; input waits meanwhile.
module sorted_table_interpolating_lookup (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // action[1:0], pos_x[33:2], pos_y[65:34], sample_time[97:66],
  // scalar_value[129:98], zero pad
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // hit[0], out_x[32:1], out_y[64:33], out_time[96:65],
  // out_scalar[128:97], dropped_flag[129], zero pad
  output logic [135:0]      out_tdata
);
  import stil_pkg::*;

  stil_cmd_t cmd;
  stil_sts_t sts;

  stil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid & in_tready),
    .in_ready  (in_tready),
    .res_valid (out_tvalid),
    .res_taken (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  stil_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_word  (in_tdata),
    .res_word (out_tdata)
  );
endmodule
`default_nettype wire

// ===== sim/tb_sorted_table_interpolating_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_interpolating_lookup: self-checking bench for the table
// drives clear/append/query words, predicts each query answer with a local
// copy of the sample table, and compares every returned word field by field
// ----------------------------------------------------------------------------
module tb_sorted_table_interpolating_lookup;
  import stil_pkg::*;

  localparam longint CycleLimit = 2000000;

  typedef struct {
    action_t      act;
    logic [31:0]  px;
    logic [31:0]  py;
    logic [31:0]  ts;
    logic [31:0]  sv;
    bit           chk;   // typed-in answer present
    bit           ehit;
    bit           edrop;
  } stim_row_t;

  typedef struct {
    bit          hit;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
    logic [31:0] s;
    bit          drop;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;

  // predictor state
  logic signed [31:0] tbl_x [MaxSamples];
  logic signed [31:0] tbl_y [MaxSamples];
  logic signed [31:0] tbl_t [MaxSamples];
  logic signed [31:0] tbl_s [MaxSamples];
  int                 fill_cnt;
  bit                 drop_seen;

  answer_t answer_q[$];
  int      fail_cnt;
  longint  cyc;
  bit      calm;     // no idling near the end

  sorted_table_interpolating_lookup dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [31:0] lerp(logic signed [31:0] a0,
                                              logic signed [31:0] a1,
                                              longint u);
    longint p;
    p = (longint'(a1) - longint'(a0)) * u;
    return 32'(longint'(a0) + (p >>> FracBits));
  endfunction

  // update the table copy, return 1 if a query answer is produced
  function automatic bit table_apply(action_t act, logic signed [31:0] px,
                                     logic signed [31:0] py,
                                     logic signed [31:0] ts,
                                     logic signed [31:0] sv, output answer_t a);
    int lo, hi, mid;
    longint num, den, u;
    a = '{default: 0};
    case (act)
      ACT_CLEAR: begin
        fill_cnt = 0;
        drop_seen = 0;
      end
      ACT_APPEND: begin
        if (fill_cnt >= MaxSamples || (fill_cnt > 0 && ts <= tbl_t[fill_cnt-1]))
          drop_seen = 1;
        else begin
          tbl_x[fill_cnt] = px; tbl_y[fill_cnt] = py;
          tbl_t[fill_cnt] = ts; tbl_s[fill_cnt] = sv;
          fill_cnt++;
        end
      end
      ACT_QUERY: begin
        a.drop = drop_seen;
        if (fill_cnt == 0 || ts < tbl_t[0] || ts > tbl_t[fill_cnt-1]) return 1;
        a.hit = 1;
        lo = 0;
        hi = fill_cnt - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (tbl_t[mid] < ts) lo = mid + 1;
          else if (tbl_t[mid] > ts) hi = mid - 1;
          else begin
            a.x = tbl_x[mid]; a.y = tbl_y[mid]; a.t = tbl_t[mid]; a.s = tbl_s[mid];
            return 1;
          end
        end
        num = longint'(ts) - longint'(tbl_t[hi]);
        den = longint'(tbl_t[lo]) - longint'(tbl_t[hi]);
        u = (num <<< FracBits) / den;
        a.x = lerp(tbl_x[hi], tbl_x[lo], u);
        a.y = lerp(tbl_y[hi], tbl_y[lo], u);
        a.t = lerp(tbl_t[hi], tbl_t[lo], u);
        a.s = lerp(tbl_s[hi], tbl_s[lo], u);
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // send one word and queue the predicted answer
  task automatic send_word(stim_row_t r);
    answer_t a;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, r.sv, r.ts, r.py, r.px, r.act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (table_apply(r.act, r.px, r.py, r.ts, r.sv, a)) begin
      if (r.chk && (a.hit != r.ehit || a.drop != r.edrop)) begin
        $error("typed answer differs: hit %0d drop %0d", r.ehit, r.edrop);
        fail_cnt++;
      end
      answer_q = {answer_q, a};
    end
  endtask

  // result side: random stalls, compare with oldest prediction
  initial begin
    answer_t e;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected word");
          fail_cnt++;
        end else begin
          e = answer_q.pop_front();
          if (out_tdata[0] !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, out_tdata[0]); fail_cnt++;
          end
          if (out_tdata[32:1] !== e.x) begin
            $error("out_x exp %h got %h", e.x, out_tdata[32:1]); fail_cnt++;
          end
          if (out_tdata[64:33] !== e.y) begin
            $error("out_y exp %h got %h", e.y, out_tdata[64:33]); fail_cnt++;
          end
          if (out_tdata[96:65] !== e.t) begin
            $error("out_time exp %h got %h", e.t, out_tdata[96:65]); fail_cnt++;
          end
          if (out_tdata[128:97] !== e.s) begin
            $error("out_scalar exp %h got %h", e.s, out_tdata[128:97]); fail_cnt++;
          end
          if (out_tdata[129] !== e.drop) begin
            $error("dropped_flag exp %0d got %0d", e.drop, out_tdata[129]); fail_cnt++;
          end
        end
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_tready <= 1'b1;
      end else
        out_tready <= 1'b1;
    end
  end

  function automatic stim_row_t mk(action_t act, logic [31:0] px, logic [31:0] py,
                                   logic [31:0] ts, logic [31:0] sv);
    stim_row_t r;
    r = '{act: act, px: px, py: py, ts: ts, sv: sv, chk: 0, ehit: 0, edrop: 0};
    return r;
  endfunction

  function automatic stim_row_t mkq(logic [31:0] ts, bit h, bit d);
    stim_row_t r;
    r = mk(ACT_QUERY, '0, '0, ts, '0);
    r.chk = 1; r.ehit = h; r.edrop = d;
    return r;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // random well-formed table then queries, with some noise
  task automatic random_phase(int n_app, int n_q);
    longint tcur;
    logic [31:0] t_first, t_last;
    action_t act;
    send_word(mk(ACT_CLEAR, rnd32(), rnd32(), rnd32(), rnd32()));
    tcur = longint'($signed($urandom())) >>> $urandom_range(0, 8);
    t_first = 32'(tcur);
    t_last = t_first;
    for (int i = 0; i < n_app; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_word(mk(ACT_APPEND, rnd32(), rnd32(), 32'(tcur - $urandom_range(0, 9)),
                     rnd32()));
      else begin
        send_word(mk(ACT_APPEND, rnd32(), rnd32(), 32'(tcur), rnd32()));
        t_last = 32'(tcur);
        tcur += $urandom_range(1, 1 << $urandom_range(0, 24));
        if (tcur > 64'sd2147483647) tcur = 64'sd2147483647;
      end
    end
    for (int i = 0; i < n_q; i++) begin
      case ($urandom_range(0, 9))
        0: send_word(mk(ACT_QUERY, '0, '0, rnd32(), '0));
        1: send_word(mk(ACT_QUERY, '0, '0, t_first, '0));
        2: send_word(mk(ACT_QUERY, '0, '0, t_last, '0));
        3: begin
          act = $urandom_range(0, 1) ? ACT_NONE : ACT_APPEND;
          send_word(mk(act, rnd32(), rnd32(), rnd32(), rnd32()));
        end
        default: send_word(mk(ACT_QUERY, '0, '0,
          32'($signed(t_first) + longint'($urandom_range(0, 32'hffff_ffff)) %
              (longint'($signed(t_last)) - longint'($signed(t_first)) + 1)), '0));
      endcase
    end
  endtask

  stim_row_t dir_rows[$];

  initial begin
    fill_cnt = 0; drop_seen = 0; fail_cnt = 0; calm = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, extremes, exact, interpolation, drops, clear, unused code
    dir_rows = '{
      mkq(32'h0, 0, 0),
      mk(ACT_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000),
      mkq(32'h8000_0000, 1, 0),
      mkq(32'h8000_0001, 0, 0),
      mk(ACT_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff),
      mkq(32'h0, 1, 0),
      mkq(32'h7fff_ffff, 1, 0),
      mkq(32'hffff_ffff, 1, 0),
      mk(ACT_APPEND, 32'h1, 32'h1, 32'h7fff_ffff, 32'h1),
      mkq(32'h1234_5678, 1, 1),
      mk(ACT_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff),
      mkq(32'h7fff_fffe, 1, 1),
      mk(ACT_CLEAR, '0, '0, '0, '0),
      mkq(32'h8000_0000, 0, 0),
      mk(ACT_APPEND, 32'h0001_0000, 32'hffff_0000, 32'h0000_0010, 32'h0),
      mk(ACT_APPEND, 32'h0003_0000, 32'hfffd_0000, 32'h0000_0013, 32'h5),
      mk(ACT_APPEND, 32'h0, 32'h0, 32'h0000_0013, 32'h0),
      mkq(32'h0000_0011, 1, 1),
      mkq(32'h0000_0012, 1, 1),
      mkq(32'h0000_0014, 0, 1)
    };
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // fill to capacity, then one append too many
    send_word(mk(ACT_CLEAR, '0, '0, '0, '0));
    for (int i = 0; i < MaxSamples; i++)
      send_word(mk(ACT_APPEND, $urandom(), $urandom(), 32'(i * 977 - 500000), $urandom()));
    send_word(mk(ACT_APPEND, '0, '0, 32'h7fff_ffff, '0));
    for (int i = 0; i < 20; i++)
      send_word(mk(ACT_QUERY, '0, '0, 32'($urandom_range(0, 1023 * 977) - 500000), '0));

    // hold off until every answer is back
    in_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);

    for (int p = 0; p < 12; p++) random_phase($urandom_range(1, 20), 25);
    calm = 1;
    random_phase(16, 40);
    in_tvalid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_cnt == 0 && answer_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
